[src/wbl_pkg.sv]
`timescale 1ns / 1ps

package wbl_pkg;

  localparam int LOG_FRACTION_BITS_DEF = 20;

  localparam int DIAM_W   = 20;
  localparam int RHO_W    = 15;
  localparam int SPEED_W  = 16;
  localparam int COS_W    = 17;
  localparam int WALL_W   = 20;
  localparam int SPACE_W  = 22;
  localparam int STRESS_W = 14;
  localparam int COEF_W   = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 3;
  localparam int IN_W     = 72;
  localparam int OUT_W    = 24;

  // Operands enter the log units as 32-bit integers; the exponent takes five bits.
  localparam int OPND_W = 32;
  localparam int EXP_W  = 5;

  localparam logic [COEF_W-1:0] COEF_RESET = 32'd552861696;
  localparam logic [DIAM_W-1:0] DC_MAX     = 20'd1000000;
  // 70 ksi in units of 1/16 ksi.
  localparam longint unsigned STRESS_REF = 64'd1120;

  localparam logic [IDX_W-1:0] REG_WALL   = 3'd0;
  localparam logic [IDX_W-1:0] REG_BUMPER = 3'd1;
  localparam logic [IDX_W-1:0] REG_SPACE  = 3'd2;
  localparam logic [IDX_W-1:0] REG_STRESS = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEF   = 3'd4;

  typedef struct packed {
    logic [DIAM_W-1:0] diam;
    logic              inv;
    logic              sat;
    logic              zero;
    logic [5:0]        sh;
  } side_t;

  function automatic longint unsigned isqrt64(longint unsigned a);
    longint unsigned rem;
    longint unsigned r;
    longint unsigned b;
    rem = a;
    r   = 64'd0;
    b   = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-i) in Q1.31, built the same way the datapath expects it.
  function automatic longint unsigned exp_root(int i);
    longint unsigned root;
    root = 64'd1 << 32;
    for (int j = 1; j <= i; j++) begin
      root = isqrt64(root << 31);
    end
    return root;
  endfunction

  // Truncated log2 of a constant, fb fraction bits.
  function automatic longint unsigned log2_const(longint unsigned x, int fb);
    int              e;
    longint unsigned y;
    longint unsigned frac;
    e    = 0;
    frac = 64'd0;
    for (int j = 0; j < 32; j++) begin
      if (x[j]) e = j;
    end
    y = x << (31 - e);
    for (int j = 0; j < fb; j++) begin
      y    = (y * y) >> 31;
      frac = frac << 1;
      if (y >= (64'd1 << 32)) begin
        frac = frac | 64'd1;
        y    = y >> 1;
      end
    end
    return (longint'(e) << fb) + frac;
  endfunction

endpackage

[src/wbl_log2.sv]
`timescale 1ns / 1ps

module wbl_log2 #(
  parameter int FB = wbl_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [wbl_pkg::OPND_W-1:0]          x,
  output logic [wbl_pkg::EXP_W+FB-1:0]        log_out
);

  logic [wbl_pkg::EXP_W-1:0]  e_r    [0:FB];
  logic [wbl_pkg::OPND_W-1:0] y_r    [0:FB];
  logic [FB-1:0]              frac_r [0:FB];

  logic [wbl_pkg::EXP_W-1:0]  e_nxt;
  logic [wbl_pkg::OPND_W-1:0] y_nxt;

  // Leading-one position and normalization to Q1.31.
  always_comb begin
    e_nxt = '0;
    for (int j = 0; j < wbl_pkg::OPND_W; j++) begin
      if (x[j]) e_nxt = wbl_pkg::EXP_W'(j);
    end
    y_nxt = x << (5'd31 - e_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_r[0]    <= e_nxt;
      y_r[0]    <= y_nxt;
      frac_r[0] <= '0;
    end
  end

  // One squaring per stage yields one fraction bit.
  for (genvar k = 1; k <= FB; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] t;
    assign sq = 64'(y_r[k-1]) * 64'(y_r[k-1]);
    assign t  = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k]    <= e_r[k-1];
        frac_r[k] <= {frac_r[k-1][FB-2:0], t[32]};
        y_r[k]    <= t[32] ? t[32:1] : t[31:0];
      end
    end
  end

  assign log_out = {e_r[FB], frac_r[FB]};

endmodule

[src/wbl_exp2.sv]
`timescale 1ns / 1ps

module wbl_exp2 #(
  parameter int FB = wbl_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  logic [FB-1:0] f,
  output logic [31:0]   m_out
);

  logic [31:0]   m_r  [0:FB-1];
  logic [FB-1:0] f_r  [0:FB-1];
  logic [31:0]   m_in [0:FB-1];
  logic [FB-1:0] f_in [0:FB-1];

  // Stage i multiplies in 2^(2^-(i+1)) when the matching fraction bit is set.
  for (genvar i = 0; i < FB; i++) begin : g_mul
    localparam logic [31:0] ROOT = 32'(wbl_pkg::exp_root(i + 1));
    logic [63:0] prod;
    if (i == 0) begin : g_first
      assign m_in[i] = 32'h8000_0000;
      assign f_in[i] = f;
    end else begin : g_next
      assign m_in[i] = m_r[i-1];
      assign f_in[i] = f_r[i-1];
    end
    assign prod = 64'(m_in[i]) * 64'(ROOT);
    always_ff @(posedge clk) begin
      if (en) begin
        f_r[i] <= f_in[i];
        m_r[i] <= f_in[i][FB-1-i] ? prod[62:31] : m_in[i];
      end
    end
  end

  assign m_out = m_r[FB-1];

endmodule

[src/whipple_ballistic_limit.sv]
`timescale 1ns / 1ps

// Whipple shield ballistic limit, one impact per word.
// The in_ channel carries one impact per word; the out_ channel returns the
// critical diameter with the penetration and invalid flags, one word each.
// Shield geometry sits in registers written through the cfg_ port, which must be
// only written while no word is in flight; the block itself does not enforce this.
// The word passes a normalize register loaded at the accepting edge,
// LOG_FRACTION_BITS squaring stages in the log2 units, four stages for the
// weighted sum and the divide by nine, LOG_FRACTION_BITS multiply stages in
// the exp2 unit and the output register; out_tvalid rises as the word is
// loaded into the output register.
// Throughput is one word per cycle. Every stage moves together; when the
// receiver holds out_tready low with a word waiting, the whole pipeline
// holds and in_tready drops, so nothing is lost or repeated.
// Reset clears the valid bits and the configuration registers to their reset values.
module whipple_ballistic_limit #(
  parameter int LOG_FRACTION_BITS = wbl_pkg::LOG_FRACTION_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // projectile_diameter_um[19:0], projectile_density[34:20],
  // impact_speed[50:35], impact_cosine[67:51], zero pad[71:68]
  input  logic [wbl_pkg::IN_W-1:0]    in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // critical_diameter_um[19:0], penetrates[20], invalid[21], zero pad[23:22]
  output logic [wbl_pkg::OUT_W-1:0]   out_tdata,
  input  logic                        cfg_wr_en,
  input  logic [wbl_pkg::IDX_W-1:0]   cfg_index,
  input  logic [wbl_pkg::CFG_W-1:0]   cfg_wdata
);

  localparam int FB   = LOG_FRACTION_BITS;
  localparam int LW   = wbl_pkg::EXP_W + FB;
  localparam int SW   = FB + 12;
  localparam int UW   = FB + 15;
  localparam int KSH  = FB + 15;
  localparam int MW   = FB + 12;
  localparam int IC   = FB + 3;
  localparam int ID   = FB + 4;
  localparam int LAST = 2 * FB + 5;

  localparam logic [MW-1:0] RECIP9 = MW'((64'd1 << KSH) / 64'd9);
  localparam logic [UW-1:0] BIAS   = UW'(64'd9 << (FB + 11));
  localparam logic [SW-1:0] ONE16  = SW'(64'd16 << FB);
  localparam logic [SW-1:0] LREF   = SW'(wbl_pkg::log2_const(wbl_pkg::STRESS_REF, FB));
  localparam logic [MW:0]   LBIAS  = (MW+1)'(64'd1 << (FB + 11));

  // Configuration registers
  logic [wbl_pkg::WALL_W-1:0]   wall_r;
  logic [wbl_pkg::RHO_W-1:0]    bumper_r;
  logic [wbl_pkg::SPACE_W-1:0]  space_r;
  logic [wbl_pkg::STRESS_W-1:0] stress_r;
  logic [wbl_pkg::COEF_W-1:0]   coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wall_r   <= '0;
      bumper_r <= '0;
      space_r  <= '0;
      stress_r <= '0;
      coef_r   <= wbl_pkg::COEF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        wbl_pkg::REG_WALL:   wall_r   <= cfg_wdata[wbl_pkg::WALL_W-1:0];
        wbl_pkg::REG_BUMPER: bumper_r <= cfg_wdata[wbl_pkg::RHO_W-1:0];
        wbl_pkg::REG_SPACE:  space_r  <= cfg_wdata[wbl_pkg::SPACE_W-1:0];
        wbl_pkg::REG_STRESS: stress_r <= cfg_wdata[wbl_pkg::STRESS_W-1:0];
        wbl_pkg::REG_COEF:   coef_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input fields
  logic [wbl_pkg::DIAM_W-1:0]  in_diam;
  logic [wbl_pkg::RHO_W-1:0]   in_rho;
  logic [wbl_pkg::SPEED_W-1:0] in_speed;
  logic [wbl_pkg::COS_W-1:0]   in_cos;
  logic                        in_inv;

  assign in_diam  = in_tdata[19:0];
  assign in_rho   = in_tdata[34:20];
  assign in_speed = in_tdata[50:35];
  assign in_cos   = in_tdata[67:51];

  assign in_inv = in_cos[wbl_pkg::COS_W-1] || (in_cos == '0) || (in_speed == '0) ||
                  (in_rho == '0) || (wall_r == '0) || (bumper_r == '0) ||
                  (space_r == '0) || (stress_r == '0) || (coef_r == '0);

  // Pipeline control
  logic adv;
  logic vld_r [0:LAST];

  assign adv       = !vld_r[LAST] || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAST; k++) vld_r[k] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k <= LAST; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Log2 lanes
  logic [LW-1:0] lk, lt, lb, lrp, lv, lc, ls, lsy;

  wbl_log2 #(.FB(FB)) u_log_coef (.clk(clk), .en(adv), .x(coef_r), .log_out(lk));
  wbl_log2 #(.FB(FB)) u_log_wall (.clk(clk), .en(adv), .x(32'(wall_r)), .log_out(lt));
  wbl_log2 #(.FB(FB)) u_log_bump (.clk(clk), .en(adv), .x(32'(bumper_r)), .log_out(lb));
  wbl_log2 #(.FB(FB)) u_log_rho  (.clk(clk), .en(adv), .x(32'(in_rho)), .log_out(lrp));
  wbl_log2 #(.FB(FB)) u_log_spd  (.clk(clk), .en(adv), .x(32'(in_speed)), .log_out(lv));
  wbl_log2 #(.FB(FB)) u_log_cos  (.clk(clk), .en(adv), .x(32'(in_cos)), .log_out(lc));
  wbl_log2 #(.FB(FB)) u_log_spc  (.clk(clk), .en(adv), .x(32'(space_r)), .log_out(ls));
  wbl_log2 #(.FB(FB)) u_log_str  (.clk(clk), .en(adv), .x(32'(stress_r)), .log_out(lsy));

  // Weighted sum, nine times the log of the result
  logic signed [SW-1:0] p1_r, p2_r, p3_r, p4_r;
  logic signed [SW-1:0] p1_nxt, p2_nxt, p3_nxt, p4_nxt;

  always_comb begin
    p1_nxt = 9 * ($signed(SW'(lk)) - $signed(ONE16)) + 6 * $signed(SW'(lt));
    p2_nxt = -$signed(SW'(lb)) - 3 * $signed(SW'(lrp));
    p3_nxt = -6 * ($signed(SW'(lv)) + $signed(SW'(lc)) - $signed(ONE16));
    p4_nxt = 3 * ($signed(SW'(ls)) + $signed(SW'(lsy)) - $signed(LREF));
  end

  // Biased so that floor division by nine works on an unsigned value.
  logic [UW-1:0] u_r;
  logic [UW-1:0] u_nxt;
  logic [UW-1:0] u_c_r;
  logic [MW-1:0] q0_r;
  logic [UW+MW-1:0] prod9;

  assign u_nxt = UW'($signed(UW'(p1_r)) + $signed(UW'(p2_r)) + $signed(UW'(p3_r)) +
                     $signed(UW'(p4_r))) + UW'(4) + BIAS;
  assign prod9 = (UW+MW)'(u_r) * (UW+MW)'(RECIP9);

  // Quotient correction, then integer and fraction parts of the log.
  logic [UW-1:0]        rem9;
  logic [MW-1:0]        q;
  logic signed [MW:0]   l;
  logic signed [MW-FB:0] n;
  logic [FB-1:0]        f_d_r;
  wbl_pkg::side_t       side_d;

  assign rem9 = u_c_r - UW'(q0_r) * UW'(9);
  assign q    = (rem9 >= UW'(9)) ? q0_r + MW'(1) : q0_r;
  assign l    = $signed({1'b0, q}) - $signed(LBIAS);
  assign n    = l[MW:FB];

  wbl_pkg::side_t side_r [0:LAST-1];
  wbl_pkg::side_t side_in;

  always_comb begin
    side_in      = '0;
    side_in.diam = in_diam;
    side_in.inv  = in_inv;
    side_d       = side_r[IC];
    side_d.sat   = (n >= 21);
    side_d.zero  = (n < -1);
    side_d.sh    = 6'(7'sd31 - 7'(n));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r  <= p1_nxt;
      p2_r  <= p2_nxt;
      p3_r  <= p3_nxt;
      p4_r  <= p4_nxt;
      u_r   <= u_nxt;
      u_c_r <= u_r;
      q0_r  <= MW'(prod9 >> KSH);
      f_d_r <= l[FB-1:0];
      side_r[0] <= side_in;
      for (int k = 1; k < LAST; k++) begin
        if (k == ID) side_r[k] <= side_d;
        else         side_r[k] <= side_r[k-1];
      end
    end
  end

  // Mantissa rebuild
  logic [31:0] m;

  wbl_exp2 #(.FB(FB)) u_exp (.clk(clk), .en(adv), .f(f_d_r), .m_out(m));

  // Round to micrometres, saturate and compare.
  wbl_pkg::side_t             se;
  logic [32:0]                rnd;
  logic [21:0]                d;
  logic [wbl_pkg::DIAM_W-1:0] dc_nxt;
  logic                       pen_nxt;
  logic                       inv_nxt;
  logic [wbl_pkg::DIAM_W-1:0] dc_r;
  logic                       pen_r;
  logic                       inv_r;

  assign se = side_r[LAST-1];

  always_comb begin
    rnd = 33'(m) + (33'd1 << (se.sh - 6'd1));
    d   = se.zero ? '0 : 22'(rnd >> se.sh);
    if (se.inv) begin
      dc_nxt  = '0;
      pen_nxt = 1'b0;
      inv_nxt = 1'b1;
    end else if (se.sat) begin
      dc_nxt  = wbl_pkg::DC_MAX;
      pen_nxt = 1'b0;
      inv_nxt = 1'b0;
    end else begin
      dc_nxt  = (d > 22'(wbl_pkg::DC_MAX)) ? wbl_pkg::DC_MAX : d[wbl_pkg::DIAM_W-1:0];
      pen_nxt = 22'(se.diam) > d;
      inv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dc_r  <= dc_nxt;
      pen_r <= pen_nxt;
      inv_r <= inv_nxt;
    end
  end

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {2'b00, inv_r, pen_r, dc_r};

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int DIAM_W   = wbl_pkg::DIAM_W;
  localparam int RHO_W    = wbl_pkg::RHO_W;
  localparam int SPEED_W  = wbl_pkg::SPEED_W;
  localparam int COS_W    = wbl_pkg::COS_W;
  localparam int WALL_W   = wbl_pkg::WALL_W;
  localparam int SPACE_W  = wbl_pkg::SPACE_W;
  localparam int STRESS_W = wbl_pkg::STRESS_W;
  localparam int COEF_W   = wbl_pkg::COEF_W;
  localparam int CFG_W    = wbl_pkg::CFG_W;
  localparam int IDX_W    = wbl_pkg::IDX_W;
  localparam int IN_W     = wbl_pkg::IN_W;
  localparam int OUT_W    = wbl_pkg::OUT_W;

  localparam int FB = wbl_pkg::LOG_FRACTION_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [DIAM_W-1:0]  diam;
    logic [RHO_W-1:0]   rho;
    logic [SPEED_W-1:0] speed;
    logic [COS_W-1:0]   cosine;
  } impact_t;

  typedef struct packed {
    logic [DIAM_W-1:0] dc;
    logic              pen;
    logic              inv;
  } limit_t;

  typedef struct packed {
    impact_t imp;
    logic    typed;
    limit_t  res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [IDX_W-1:0] cfg_index = wbl_pkg::REG_WALL;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Shield registers as the predictor sees them.
  logic [WALL_W-1:0]   wall_um = '0;
  logic [RHO_W-1:0]    bumper_rho = '0;
  logic [SPACE_W-1:0]  spacing_um = '0;
  logic [STRESS_W-1:0] yield_st = '0;
  logic [COEF_W-1:0]   coef = wbl_pkg::COEF_RESET;

  longint unsigned half_roots [1:FB];
  limit_t  pending_limits[$];
  int      idle_mode = 0;
  bit      hold_req = 1'b0;
  bit      hold_done = 1'b0;
  int      hold_left = 0;
  int      errors = 0;
  longint  cycles = 0;

  whipple_ballistic_limit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Truncated log2 of a positive operand, FB fraction bits.
  function automatic longint log2_trunc(longint unsigned x);
    int e;
    longint unsigned y;
    longint fr;
    e = 31;
    fr = 0;
    while (e > 0 && x[e] == 1'b0) e--;
    y = x << (31 - e);
    for (int i = 0; i < FB; i++) begin
      y = (y * y) >> 31;
      fr = fr << 1;
      if (y >= (64'd1 << 32)) begin
        fr = fr | 1;
        y = y >> 1;
      end
    end
    return (longint'(e) << FB) + fr;
  endfunction

  function automatic longint floor_div9(longint a);
    longint q;
    q = a / 9;
    if ((a % 9) < 0) q--;
    return q;
  endfunction

  function automatic limit_t critical_limit(impact_t t);
    limit_t r;
    longint nine_l, l, n, f;
    longint unsigned m, d;
    int sh;
    r = '0;
    if (t.cosine[COS_W-1] || t.cosine == 0 || t.speed == 0 || t.rho == 0 ||
        wall_um == 0 || bumper_rho == 0 || spacing_um == 0 || yield_st == 0 ||
        coef == 0) begin
      r.inv = 1'b1;
      return r;
    end
    nine_l = 9 * (log2_trunc(coef) - 16 * ONE) + 6 * log2_trunc(wall_um)
           - log2_trunc(bumper_rho) - 3 * log2_trunc(t.rho)
           - 6 * (log2_trunc(t.speed) + log2_trunc(t.cosine) - 16 * ONE)
           + 3 * log2_trunc(spacing_um)
           + 3 * (log2_trunc(yield_st) - log2_trunc(64'd1120));
    l = floor_div9(nine_l + 4);
    n = l >>> FB;
    f = l - n * ONE;
    if (n >= 21) begin
      r.dc = wbl_pkg::DC_MAX;
      return r;
    end
    m = 64'd1 << 31;
    for (int i = 1; i <= FB; i++) begin
      if (f[FB-i]) m = (m * half_roots[i]) >> 31;
    end
    sh = 31 - int'(n);
    if (sh >= 64) d = 0;
    else d = (m + (64'd1 << (sh - 1))) >> sh;
    r.pen = (t.diam > d);
    r.dc = (d > wbl_pkg::DC_MAX) ? wbl_pkg::DC_MAX : d[DIAM_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
  endtask

  task automatic set_shield(input logic [WALL_W-1:0] w, input logic [RHO_W-1:0] b,
                            input logic [SPACE_W-1:0] s, input logic [STRESS_W-1:0] y,
                            input logic [COEF_W-1:0] k);
    write_reg(wbl_pkg::REG_WALL, CFG_W'(w));
    write_reg(wbl_pkg::REG_BUMPER, CFG_W'(b));
    write_reg(wbl_pkg::REG_SPACE, CFG_W'(s));
    write_reg(wbl_pkg::REG_STRESS, CFG_W'(y));
    write_reg(wbl_pkg::REG_COEF, k);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wall_um = w; bumper_rho = b; spacing_um = s; yield_st = y; coef = k;
  endtask

  function automatic bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 71;
      3: return $urandom_range(99) < 9;
      default: return 1'b0;
    endcase
  endfunction

  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic send_impact(input impact_t t, input bit typed, input limit_t res);
    while (sender_idles()) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, t.cosine, t.speed, t.rho, t.diam};
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    pending_limits.push_back(typed ? res : critical_limit(t));
  endtask

  // Called at the edge that accepted the last word.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_limits.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic impact_t random_impact();
    impact_t t;
    limit_t p;
    t.rho = ($urandom_range(19) == 0) ? '0 : RHO_W'($urandom_range(1, 32767));
    t.speed = ($urandom_range(19) == 0) ? '0 : SPEED_W'($urandom_range(1, 65535));
    t.cosine = ($urandom_range(9) == 0) ? COS_W'($urandom) :
               COS_W'($urandom_range(1, 65535));
    t.diam = DIAM_W'($urandom_range(0, 1000000));
    // Aim most diameters at the limit so the penetration flag flips often.
    if ($urandom_range(3) != 0) begin
      p = critical_limit(t);
      if (!p.inv && p.dc < wbl_pkg::DC_MAX - 4 && p.dc > 4)
        t.diam = p.dc + DIAM_W'($urandom_range(0, 4)) - 2;
    end
    return t;
  endfunction

  always @(posedge clk) begin
    if (hold_req && !hold_done && hold_left == 0) begin
      hold_left <= 500;
      hold_done <= 1'b1;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (idle_mode == 2) begin
      out_tready <= $urandom_range(99) >= 71;
    end else if (idle_mode == 3) begin
      out_tready <= $urandom_range(99) >= 9;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // out_tready and out_tvalid only change at rising edges, so the middle of
  // the cycle shows what the next edge will accept.
  always @(negedge clk) begin
    limit_t got, want;
    if (out_tvalid && out_tready) begin
      got = {out_tdata[19:0], out_tdata[20], out_tdata[21]};
      if (pending_limits.size() == 0) begin
        $display("%0t: unexpected word, got dc=%0d pen=%0d inv=%0d", $time,
                 got.dc, got.pen, got.inv);
        errors++;
      end else begin
        want = pending_limits.pop_front();
        if (got !== want || out_tdata[23:22] !== 2'b00) begin
          $display("%0t: expected dc=%0d pen=%0d inv=%0d, got dc=%0d pen=%0d inv=%0d",
                   $time, want.dc, want.pen, want.inv, got.dc, got.pen, got.inv);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    row_t dir [$];
    limit_t bad;
    impact_t t;
    int phase;
    bad = '{dc: '0, pen: 1'b0, inv: 1'b1};
    half_roots[1] = int_sqrt((64'd1 << 32) << 31);
    for (int i = 2; i <= FB; i++) half_roots[i] = int_sqrt(half_roots[i-1] << 31);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Straight out of reset the wall is zero, so every impact is invalid.
    send_impact('{20'd5000, 15'd2700, 16'd7000, 17'd65535}, 1'b1, bad);
    drain();

    set_shield(20'd3000, 15'd2700, 22'd100000, 14'd640, wbl_pkg::COEF_RESET);
    dir = '{
      '{'{20'd1000, 15'd0, 16'd7000, 17'd65535}, 1'b1, bad},
      '{'{20'd1000, 15'd2700, 16'd0, 17'd65535}, 1'b1, bad},
      '{'{20'd1000, 15'd2700, 16'd7000, 17'd0}, 1'b1, bad},
      '{'{20'd1000, 15'd2700, 16'd7000, 17'h10000}, 1'b1, bad},
      '{'{20'd1000, 15'd2700, 16'd7000, 17'h1FFFF}, 1'b1, bad},
      '{'{20'd0, 15'd2700, 16'd7000, 17'd65535}, 1'b0, bad},
      '{'{20'd1000000, 15'd2700, 16'd7000, 17'd65535}, 1'b0, bad},
      '{'{20'd1000, 15'd32767, 16'd65535, 17'd65535}, 1'b0, bad},
      '{'{20'd1000, 15'd1, 16'd1, 17'd1}, 1'b0, bad},
      '{'{20'd1000, 15'd1, 16'd7000, 17'd65535}, 1'b0, bad},
      '{'{20'd1000, 15'd2700, 16'd1, 17'd65535}, 1'b0, bad},
      '{'{20'd1000, 15'd2700, 16'd7000, 17'd1}, 1'b0, bad},
      '{'{20'd1000, 15'd2700, 16'd7000, 17'd32768}, 1'b0, bad},
      '{'{20'hFFFFF & 20'd524288, 15'd16384, 16'd32768, 17'd46341}, 1'b0, bad}
    };
    foreach (dir[i]) send_impact(dir[i].imp, dir[i].typed, dir[i].res);
    drain();

    // Tiny critical diameter: thin wall, fast dense projectile.
    set_shield(20'd1, 15'd32767, 22'd1, 14'd1, 32'd1);
    send_impact('{20'd1, 15'd32767, 16'd65535, 17'd65535}, 1'b0, bad);
    send_impact('{20'd0, 15'd32767, 16'd65535, 17'd65535}, 1'b0, bad);
    drain();
    set_shield(20'd3000, 15'd2700, 22'd100000, 14'd640, 32'd0);
    send_impact('{20'd1000, 15'd2700, 16'd7000, 17'd65535}, 1'b1, bad);
    drain();

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1: set_shield(20'd1000000, 15'd32767, 22'd4000000, 14'd16383, 32'hFFFFFFFF);
        4: set_shield(20'd1, 15'd1, 22'd1, 14'd1, 32'd1);
        default:
          set_shield(WALL_W'($urandom_range(1, 1000000)), RHO_W'($urandom_range(1, 32767)),
                     SPACE_W'($urandom_range(1, 4000000)),
                     STRESS_W'($urandom_range(1, 16383)), COEF_W'($urandom));
      endcase
      idle_mode = phase % 4;
      hold_req = (phase == 2);
      for (int i = 0; i < 150; i++) begin
        t = random_impact();
        send_impact(t, 1'b0, bad);
      end
      drain();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[sim.f]
src/wbl_pkg.sv
src/wbl_log2.sv
src/wbl_exp2.sv
src/whipple_ballistic_limit.sv
bench/testbench.sv
